@@ rtl/core/afr_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the addressed frame receiver.
package afr_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam logic [7:0] CRC_POLY = 8'h5D;

    localparam int ADDR_REG_W       = 6;
    localparam int CFG_W            = 8;
    localparam logic [7:0] START_BYTE_RESET = 8'd126;

    // Configuration register indexes.
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_START_BYTE  = 1'b1;

    // Item kinds as carried in tuser.
    localparam logic REQ_BUS  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRC   = 3'd4,
        PH_AVAIL = 3'd5
    } phase_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic       is_read;
        logic [7:0] data;
        logic       is_start;
        logic       addr_match;
    } q_item_t;

    // MSB-first CRC-8 over one byte, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] c;
        c = crc ^ din;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/afr_front.sv @@
// Input side: configuration registers and classification of incoming items.
module afr_front
    import afr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             q_full,
    output logic             q_push,
    output q_item_t          q_item
);

    logic [ADDR_REG_W-1:0] own_address_reg;
    logic [7:0]            start_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            start_byte_reg  <= START_BYTE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OWN_ADDRESS: own_address_reg <= cfg_wdata[ADDR_REG_W-1:0];
                CFG_START_BYTE:  start_byte_reg  <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Address and start comparisons are done here so the back end only branches.
    always_comb
    begin
        q_item.is_read    = (s_tuser == REQ_READ);
        q_item.data       = s_tdata;
        q_item.is_start   = (s_tdata == start_byte_reg);
        q_item.addr_match = (s_tdata == {{(8-ADDR_REG_W){1'b0}}, own_address_reg});
    end

endmodule

@@ rtl/core/afr_queue.sv @@
// Two-entry queue of classified items between the front and back ends.
module afr_queue
    import afr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    valid,
    output q_item_t head
);

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/afr_back.sv @@
// Back end: frame state machine, CRC, payload store and the output register.
module afr_back
    import afr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  q_item_t q_head,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output logic [2:0] rx_state,
    output logic    frame_done,
    output logic    frame_error,
    output logic [7:0] read_byte,
    output logic    read_valid,
    output logic    read_last
);

    phase_t           phase_reg,  phase_next;
    logic [7:0]       len_reg,    len_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [CNT_W-1:0] rp_reg,     rp_next;
    logic [7:0]       crc_reg,    crc_next;

    logic [CNT_W-1:0] rp_inc;
    logic [CNT_W-1:0] len_ext;
    logic [CNT_W-1:0] cnt_inc;
    logic             advance;
    logic             wr_en;
    logic             rd_en;
    logic             done_c, err_c, rvalid_c, rlast_c;

    logic             out_valid_reg;
    logic [2:0]       state_out_reg;
    logic             done_reg, err_reg, rvalid_reg, rlast_reg;
    logic [7:0]       rdata_reg;

    logic [7:0]       store_mem [BUFFER_DEPTH];

    // The output register frees up whenever its item is taken.
    assign advance = q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = advance;

    assign rp_inc  = rp_reg + CNT_W'(1);
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign len_ext = CNT_W'(len_reg);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        rp_next    = rp_reg;
        crc_next   = crc_reg;
        done_c     = 1'b0;
        err_c      = 1'b0;
        rvalid_c   = 1'b0;
        rlast_c    = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        if (advance)
        begin
            if (q_head.is_read)
            begin
                if (phase_reg == PH_AVAIL)
                begin
                    if (rp_reg < len_ext)
                    begin
                        rd_en    = 1'b1;
                        rvalid_c = 1'b1;
                        rp_next  = rp_inc;
                        if (rp_inc >= len_ext)
                        begin
                            rlast_c    = 1'b1;
                            phase_next = PH_WAIT;
                        end
                    end
                    else
                    begin
                        // An empty frame has nothing to read.
                        phase_next = PH_WAIT;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        phase_next = q_head.addr_match ? PH_LEN : PH_WAIT;
                    end
                    PH_LEN:
                    begin
                        len_next = q_head.data;
                        cnt_next = '0;
                        crc_next = '0;
                        if (CNT_W'(q_head.data) > CNT_W'(BUFFER_DEPTH))
                        begin
                            err_c      = 1'b1;
                            phase_next = PH_WAIT;
                        end
                        else if (q_head.data == 8'd0)
                        begin
                            phase_next = PH_CRC;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        wr_en    = (cnt_reg < CNT_W'(BUFFER_DEPTH));
                        crc_next = crc8_update(crc_reg, q_head.data);
                        cnt_next = cnt_inc;
                        if (cnt_inc >= len_ext)
                        begin
                            phase_next = PH_CRC;
                        end
                    end
                    PH_CRC:
                    begin
                        if (q_head.data == crc_reg)
                        begin
                            done_c     = 1'b1;
                            rp_next    = '0;
                            phase_next = PH_AVAIL;
                        end
                        else
                        begin
                            err_c      = 1'b1;
                            phase_next = PH_WAIT;
                        end
                    end
                    PH_AVAIL:
                    begin
                        phase_next = PH_AVAIL;
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                        if (q_head.is_start)
                        begin
                            cnt_next   = '0;
                            crc_next   = '0;
                            phase_next = PH_ADDR;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            len_reg       <= '0;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
            state_out_reg <= PH_WAIT;
            done_reg      <= 1'b0;
            err_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            rlast_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            rp_reg    <= rp_next;
            crc_reg   <= crc_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_out_reg <= phase_next;
                done_reg      <= done_c;
                err_reg       <= err_c;
                rvalid_reg    <= rvalid_c;
                rlast_reg     <= rlast_c;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[cnt_reg[ADDR_W-1:0]] <= q_head.data;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[rp_reg[ADDR_W-1:0]];
        end
    end

    assign out_valid   = out_valid_reg;
    assign rx_state    = state_out_reg;
    assign frame_done  = done_reg;
    assign frame_error = err_reg;
    assign read_valid  = rvalid_reg;
    assign read_last   = rlast_reg;
    assign read_byte   = rvalid_reg ? rdata_reg : 8'd0;

endmodule

@@ rtl/core/addressed_frame_receiver_crc8_unit.sv @@
// Top level of the addressed frame receiver with CRC-8 check.
//
// The slave channel takes one item per handshake: tuser says whether it is a
// byte from the bus or a host read of one payload byte, tdata carries the bus
// byte. A frame is start byte, address byte, length byte, payload and a CRC-8
// byte (polynomial 0x5D, initial value zero). After a good frame the host
// drains the payload with read items; the last byte read reopens the receiver.
// Every item gives exactly one result item on the master channel: the phase
// after the item, done and error flags, and the payload byte for a read.
// An accepted item enters a two-entry queue and its result is presented from
// the output register; with m_tready high, one item per cycle is sustained, set
// by the back end's single state-machine step and one-write, one-read payload store.
// If the master side stalls, the output register holds its item and the queue
// absorbs up to two more before s_tready falls.
// Reset empties the queue, returns to waiting for a start byte and restores
// own_address to 0 and start_byte to 126; the payload store is not cleared.
// Configuration writes are taken at once and belong to idle periods only.
module addressed_frame_receiver_crc8_unit
    import afr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] bus_byte
    input  logic             s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [2:0] rx_state, [3] frame_done, [4] frame_error,
                                        // [12:5] read_byte, [15:13] zero
    output logic             m_tuser,   // [0] read_valid
    output logic             m_tlast    // read_last
);

    logic    q_full;
    logic    q_push;
    q_item_t q_in;
    logic    q_valid;
    logic    q_pop;
    q_item_t q_head;

    logic [2:0] rx_state;
    logic       frame_done;
    logic       frame_error;
    logic [7:0] read_byte;

    afr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    afr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    afr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .rx_state    (rx_state),
        .frame_done  (frame_done),
        .frame_error (frame_error),
        .read_byte   (read_byte),
        .read_valid  (m_tuser),
        .read_last   (m_tlast)
    );

    assign m_tdata = {3'b000, read_byte, frame_error, frame_done, rx_state};

endmodule
